### hdl/vad_pkg.sv
package vad_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned COMP_W_DEF = 32;
  localparam int unsigned ANGLE_W    = 24;
  localparam int unsigned POS_W      = $clog2(DATA_W);

  // normalized component: magnitude below 2^30, signed
  localparam int unsigned MAG_W   = 30;
  localparam int unsigned NORM_W  = MAG_W + 1;
  localparam int unsigned NORM_LAT = 3;

  localparam int unsigned PROD_W  = 2 * NORM_W;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned NRM2_W  = 62;
  localparam int unsigned ROOT_W  = NRM2_W / 2;
  localparam int unsigned DEN_SH  = 28;
  localparam int unsigned DMAG_W  = SUM_W - DEN_SH;
  localparam int unsigned DEN_W   = 2 * ROOT_W - DEN_SH;
  localparam int unsigned DMAG_HI = DMAG_W / 2;
  localparam int unsigned DMAG_LO = DMAG_W - DMAG_HI;

  localparam int unsigned DVD_W   = 64;
  localparam int unsigned FRAC_SH = 30;
  localparam int unsigned Q_W     = 32;
  localparam int unsigned C_W     = 31;
  localparam logic [C_W-1:0] ONE_Q30 = C_W'(1) << FRAC_SH;

  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CX_W = 34;
  localparam int unsigned CZ_W = 33;
  localparam int unsigned RAD_W = 32;

  localparam logic [RAD_W-1:0] PI_Q30      = 32'd3373259426;
  localparam logic [29:0]      RAD2DEG_Q24 = 30'd961263669;
  localparam int unsigned      DEG_PROD_W  = RAD_W + 30;
  localparam int unsigned      DEG_SH      = 38;
  localparam logic [ANGLE_W-1:0] DEG_MAX   = 24'd11796480;

  typedef struct packed {
    logic vld;
    logic degen;
    logic neg;
  } tag_t;

  function automatic logic [CZ_W-1:0] atan_q30(input int unsigned i);
    logic [CZ_W-1:0] r;
    case (i)
      0:  r = CZ_W'(32'h3243F6A8);
      1:  r = CZ_W'(32'h1DAC6705);
      2:  r = CZ_W'(32'h0FADBAFC);
      3:  r = CZ_W'(32'h07F56EA6);
      4:  r = CZ_W'(32'h03FEAB76);
      5:  r = CZ_W'(32'h01FFD55B);
      6:  r = CZ_W'(32'h00FFFAAA);
      7:  r = CZ_W'(32'h007FFF55);
      8:  r = CZ_W'(32'h003FFFEA);
      9:  r = CZ_W'(32'h001FFFFD);
      10: r = CZ_W'(32'h000FFFFF);
      11: r = CZ_W'(32'h0007FFFF);
      12: r = CZ_W'(32'h0003FFFF);
      13: r = CZ_W'(32'h0001FFFF);
      14: r = CZ_W'(32'h0000FFFF);
      15: r = CZ_W'(32'h00007FFF);
      16: r = CZ_W'(32'h00003FFF);
      17: r = CZ_W'(32'h00001FFF);
      18: r = CZ_W'(32'h00000FFF);
      19: r = CZ_W'(32'h000007FF);
      20: r = CZ_W'(32'h000003FF);
      21: r = CZ_W'(32'h000001FF);
      22: r = CZ_W'(32'h000000FF);
      23: r = CZ_W'(32'h0000007F);
      24: r = CZ_W'(32'h0000003F);
      25: r = CZ_W'(32'h0000001F);
      26: r = CZ_W'(32'h0000000F);
      27: r = CZ_W'(32'h00000007);
      28: r = CZ_W'(32'h00000003);
      29: r = CZ_W'(32'h00000001);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hdl/vad_if.sv
interface vad_in_if import vad_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [DATA_W-1:0] u_x, u_y, u_z, v_x, v_y, v_z;

  modport source (output valid, u_x, u_y, u_z, v_x, v_y, v_z, input ready);
  modport sink   (input valid, u_x, u_y, u_z, v_x, v_y, v_z, output ready);
endinterface

interface vad_out_if import vad_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle_deg;
  logic               degenerate;

  modport source (output valid, angle_deg, degenerate, input ready);
  modport sink   (input valid, angle_deg, degenerate, output ready);
endinterface

### hdl/vad_norm.sv
module vad_norm import vad_pkg::*; #(
  parameter int unsigned CompW = COMP_W_DEF
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [DATA_W-1:0]        raw_i [3],
  output logic signed [NORM_W-1:0] comp_o [3],
  output logic                     zero_o
);

  logic signed [DATA_W-1:0] ext [3];
  logic [DATA_W-1:0] mag_a_d [3];
  logic [DATA_W-1:0] mag_a_q [3];
  logic [DATA_W-1:0] mag_b_q [3];
  logic [2:0]        sgn_a_d, sgn_a_q, sgn_b_q;
  logic [DATA_W-1:0] max_a_d, max_a_q;
  logic [POS_W-1:0]  pos_b_d, pos_b_q;
  logic              zero_b_q, zero_c_q;
  logic [POS_W-1:0]  rsh, lsh;
  logic signed [NORM_W-1:0] comp_c_d [3];
  logic signed [NORM_W-1:0] comp_c_q [3];
  logic [MAG_W-1:0]  scaled [3];

  // stage A: sign extend, magnitudes, largest magnitude
  always_comb begin
    max_a_d = '0;
    for (int i = 0; i < 3; i++) begin
      ext[i]     = DATA_W'(signed'(raw_i[i][CompW-1:0]));
      sgn_a_d[i] = ext[i][DATA_W-1];
      mag_a_d[i] = sgn_a_d[i] ? DATA_W'(-ext[i]) : DATA_W'(ext[i]);
      if (mag_a_d[i] > max_a_d) max_a_d = mag_a_d[i];
    end
  end

  // stage B: leading one of the largest magnitude
  always_comb begin
    pos_b_d = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (max_a_q[i]) pos_b_d = POS_W'(i);
    end
  end

  // stage C: bring the leading one to bit MAG_W-1
  always_comb begin
    rsh = (pos_b_q >= POS_W'(MAG_W)) ? pos_b_q - POS_W'(MAG_W - 1) : '0;
    lsh = (pos_b_q <  POS_W'(MAG_W)) ? POS_W'(MAG_W - 1) - pos_b_q : '0;
    for (int i = 0; i < 3; i++) begin
      scaled[i]   = MAG_W'((mag_b_q[i] >> rsh) << lsh);
      comp_c_d[i] = sgn_b_q[i] ? -signed'(NORM_W'(scaled[i])) : signed'(NORM_W'(scaled[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_a_q  <= mag_a_d;
      sgn_a_q  <= sgn_a_d;
      max_a_q  <= max_a_d;
      mag_b_q  <= mag_a_q;
      sgn_b_q  <= sgn_a_q;
      pos_b_q  <= pos_b_d;
      zero_b_q <= (max_a_q == '0);
      comp_c_q <= comp_c_d;
      zero_c_q <= zero_b_q;
    end
  end

  assign comp_o = comp_c_q;
  assign zero_o = zero_c_q;

endmodule

### hdl/vad_lane.sv
module vad_lane import vad_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [NORM_W-1:0] a_i,
  input  logic signed [NORM_W-1:0] b_i,
  output logic signed [PROD_W-1:0] ab_o,
  output logic signed [PROD_W-1:0] aa_o,
  output logic signed [PROD_W-1:0] bb_o
);

  logic signed [PROD_W-1:0] ab_q, aa_q, bb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ab_q <= PROD_W'(a_i) * PROD_W'(b_i);
      aa_q <= PROD_W'(a_i) * PROD_W'(a_i);
      bb_q <= PROD_W'(b_i) * PROD_W'(b_i);
    end
  end

  assign ab_o = ab_q;
  assign aa_o = aa_q;
  assign bb_o = bb_q;

endmodule

### hdl/vad_isqrt.sv
module vad_isqrt import vad_pkg::*; #(
  parameter int unsigned NW = NRM2_W,
  parameter int unsigned PW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  tag_t            tag_i,
  input  logic [NW-1:0]   n_i,
  input  logic [PW-1:0]   pass_i,
  output tag_t            tag_o,
  output logic [NW/2-1:0] root_o,
  output logic [PW-1:0]   pass_o
);

  localparam int unsigned RW = NW / 2;

  tag_t          tag_q  [RW];
  logic [NW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [PW-1:0] pass_q [RW];

  // one root bit per stage, most significant first
  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int unsigned B = RW - 1 - k;
    tag_t          tag_in;
    logic [NW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [PW-1:0] pass_in;
    logic [NW:0]   cand;
    logic          take;

    if (k == 0) begin : g_first
      assign tag_in  = tag_i;
      assign rem_in  = n_i;
      assign root_in = '0;
      assign pass_in = pass_i;
    end else begin : g_next
      assign tag_in  = tag_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign pass_in = pass_q[k-1];
    end

    assign cand = ((NW+1)'(root_in) << (B + 1)) + ((NW+1)'(1) << (2 * B));
    assign take = {1'b0, rem_in} >= cand;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k] <= '0;
      end else if (en_i) begin
        tag_q[k] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? rem_in - cand[NW-1:0] : rem_in;
        root_q[k] <= take ? (root_in | (RW'(1) << B)) : root_in;
        pass_q[k] <= pass_in;
      end
    end
  end

  assign tag_o  = tag_q[RW-1];
  assign root_o = root_q[RW-1];
  assign pass_o = pass_q[RW-1];

endmodule

### hdl/vad_div.sv
module vad_div import vad_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  tag_t             tag_i,
  input  logic [DVD_W-1:0] dvd_i,
  input  logic [DEN_W-1:0] den_i,
  output tag_t             tag_o,
  output logic [Q_W-1:0]   quo_o
);

  localparam int unsigned SW = DEN_W + Q_W;

  tag_t             tag_q [Q_W];
  logic [DVD_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int unsigned B = Q_W - 1 - k;
    tag_t             tag_in;
    logic [DVD_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic [SW-1:0]    sub;
    logic             take;

    if (k == 0) begin : g_first
      assign tag_in = tag_i;
      assign rem_in = dvd_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign tag_in = tag_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign sub  = SW'(den_in) << B;
    assign take = SW'(rem_in) >= sub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k] <= '0;
      end else if (en_i) begin
        tag_q[k] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? rem_in - sub[DVD_W-1:0] : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= take ? (quo_in | (Q_W'(1) << B)) : quo_in;
      end
    end
  end

  assign tag_o = tag_q[Q_W-1];
  assign quo_o = quo_q[Q_W-1];

endmodule

### hdl/vad_cordic.sv
module vad_cordic import vad_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  tag_t                   tag_i,
  input  logic signed [CX_W-1:0] x_i,
  input  logic signed [CX_W-1:0] y_i,
  output tag_t                   tag_o,
  output logic signed [CZ_W-1:0] z_o
);

  tag_t                   tag_q [CORDIC_STEPS];
  logic signed [CX_W-1:0] x_q   [CORDIC_STEPS];
  logic signed [CX_W-1:0] y_q   [CORDIC_STEPS];
  logic signed [CZ_W-1:0] z_q   [CORDIC_STEPS];

  // vectoring mode: drive y to zero, accumulate the angle in z
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
    tag_t                   tag_in;
    logic signed [CX_W-1:0] x_in, y_in, dx, dy;
    logic signed [CZ_W-1:0] z_in, at;
    logic                   up;

    if (k == 0) begin : g_first
      assign tag_in = tag_i;
      assign x_in   = x_i;
      assign y_in   = y_i;
      assign z_in   = '0;
    end else begin : g_next
      assign tag_in = tag_q[k-1];
      assign x_in   = x_q[k-1];
      assign y_in   = y_q[k-1];
      assign z_in   = z_q[k-1];
    end

    assign dx = y_in >>> k;
    assign dy = x_in >>> k;
    assign at = signed'(atan_q30(k));
    assign up = !y_in[CX_W-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k] <= '0;
      end else if (en_i) begin
        tag_q[k] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k] <= up ? x_in + dx : x_in - dx;
        y_q[k] <= up ? y_in - dy : y_in + dy;
        z_q[k] <= up ? z_in + at : z_in - at;
      end
    end
  end

  assign tag_o = tag_q[CORDIC_STEPS-1];
  assign z_o   = z_q[CORDIC_STEPS-1];

endmodule

### hdl/vector_angle_3d_degrees.sv
// Angle between two 3D vectors, in degrees.
// in_i carries one item per handshake: u_x..u_z and v_x..v_z, signed Q16.16;
// only the low COMPONENT_WIDTH bits of each are used, sign-extended.
// out_o gives one result per item: angle_deg (unsigned Q8.16, 0..180) and
// degenerate, which is set with angle 0 when either vector is all zero.
// Results leave in the order the items came in.
// From acceptance to out_o.valid an item passes 3 normalize stages, 1 lane
// multiply, 2 merge, 31 square-root stages, 1 root product, 32 divider
// stages, 2 cosine stages, 31 square-root stages, 30 CORDIC stages and 3
// degree-conversion stages, the last one being the output register.
// Throughput is one item per cycle while out_o does not stall; the per-bit
// square-root and divider pipelines set the depth, not the rate.
// When out_o stalls, the whole pipeline holds and in_i.ready drops; it rises
// again in the cycle the waiting result is taken. Reset clears all valid
// bits, so no result appears until an item has passed through.
module vector_angle_3d_degrees import vad_pkg::*; #(
  parameter int unsigned COMPONENT_WIDTH = COMP_W_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vad_in_if.sink    in_i,
  vad_out_if.source out_o
);

  logic en;
  logic out_vld_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // normalize both vectors
  logic [DATA_W-1:0]        u_raw [3];
  logic [DATA_W-1:0]        v_raw [3];
  logic signed [NORM_W-1:0] a [3];
  logic signed [NORM_W-1:0] b [3];
  logic                     zero_u, zero_v;
  logic [NORM_LAT-1:0]      vld_n_q;

  assign u_raw[0] = in_i.u_x;
  assign u_raw[1] = in_i.u_y;
  assign u_raw[2] = in_i.u_z;
  assign v_raw[0] = in_i.v_x;
  assign v_raw[1] = in_i.v_y;
  assign v_raw[2] = in_i.v_z;

  vad_norm #(.CompW(COMPONENT_WIDTH)) u_norm_u (
    .clk_i, .en_i(en), .raw_i(u_raw), .comp_o(a), .zero_o(zero_u)
  );
  vad_norm #(.CompW(COMPONENT_WIDTH)) u_norm_v (
    .clk_i, .en_i(en), .raw_i(v_raw), .comp_o(b), .zero_o(zero_v)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_n_q <= '0;
    end else if (en) begin
      vld_n_q <= {vld_n_q[NORM_LAT-2:0], in_i.valid};
    end
  end

  // one lane per component
  logic signed [PROD_W-1:0] ab [3];
  logic signed [PROD_W-1:0] aa [3];
  logic signed [PROD_W-1:0] bb [3];
  tag_t                     tag_l_q;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vad_lane u_lane (
      .clk_i, .en_i(en), .a_i(a[i]), .b_i(b[i]),
      .ab_o(ab[i]), .aa_o(aa[i]), .bb_o(bb[i])
    );
  end

  // merge: sums, then sign and scaled magnitude of the dot product
  logic signed [SUM_W-1:0] dot_q, dot_abs;
  logic [NRM2_W-1:0]       nu_q, nv_q, nu2_q, nv2_q;
  logic [DMAG_W-1:0]       dmag_q;
  tag_t                    tag_m1_q, tag_m2_q;

  assign dot_abs = dot_q[SUM_W-1] ? -dot_q : dot_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dot_q  <= SUM_W'(ab[0]) + SUM_W'(ab[1]) + SUM_W'(ab[2]);
      nu_q   <= NRM2_W'(SUM_W'(aa[0]) + SUM_W'(aa[1]) + SUM_W'(aa[2]));
      nv_q   <= NRM2_W'(SUM_W'(bb[0]) + SUM_W'(bb[1]) + SUM_W'(bb[2]));
      dmag_q <= DMAG_W'(dot_abs >> DEN_SH);
      nu2_q  <= nu_q;
      nv2_q  <= nv_q;
    end
  end

  // square roots of both norms; the dot magnitude rides along split in two
  tag_t                tag_su, tag_sv;
  logic [ROOT_W-1:0]   ru, rv;
  logic [DMAG_HI-1:0]  dmag_hi;
  logic [DMAG_LO-1:0]  dmag_lo;
  tag_t                tag_m2_d;

  always_comb begin
    tag_m2_d     = tag_m1_q;
    tag_m2_d.neg = dot_q[SUM_W-1];
  end

  vad_isqrt #(.NW(NRM2_W), .PW(DMAG_HI)) u_sqrt_u (
    .clk_i, .rst_ni, .en_i(en), .tag_i(tag_m2_q), .n_i(nu2_q),
    .pass_i(dmag_q[DMAG_W-1:DMAG_LO]), .tag_o(tag_su), .root_o(ru), .pass_o(dmag_hi)
  );
  vad_isqrt #(.NW(NRM2_W), .PW(DMAG_LO)) u_sqrt_v (
    .clk_i, .rst_ni, .en_i(en), .tag_i(tag_m2_q), .n_i(nv2_q),
    .pass_i(dmag_q[DMAG_LO-1:0]), .tag_o(tag_sv), .root_o(rv), .pass_o(dmag_lo)
  );

  // denominator and cosine division
  logic [DEN_W-1:0]  den_q;
  logic [DMAG_W-1:0] dmag2_q;
  tag_t              tag_d_q, tag_q_o;
  logic [Q_W-1:0]    quo;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q   <= DEN_W'((2*ROOT_W)'((2*ROOT_W)'(ru) * (2*ROOT_W)'(rv)) >> DEN_SH);
      dmag2_q <= {dmag_hi, dmag_lo};
    end
  end

  vad_div u_div (
    .clk_i, .rst_ni, .en_i(en), .tag_i(tag_d_q),
    .dvd_i(DVD_W'(dmag2_q) << FRAC_SH), .den_i(den_q),
    .tag_o(tag_q_o), .quo_o(quo)
  );

  // clamp cosine, then form 1 - c^2
  logic [C_W-1:0]    c_q, c2_q;
  logic [NRM2_W-1:0] rsq_q;
  tag_t              tag_c_q, tag_r_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q   <= (quo > Q_W'(ONE_Q30)) ? ONE_Q30 : C_W'(quo);
      rsq_q <= (NRM2_W'(1) << (2 * FRAC_SH)) - NRM2_W'(NRM2_W'(c_q) * NRM2_W'(c_q));
      c2_q  <= c_q;
    end
  end

  tag_t              tag_y;
  logic [ROOT_W-1:0] y_root;
  logic [C_W-1:0]    c3;

  vad_isqrt #(.NW(NRM2_W), .PW(C_W)) u_sqrt_y (
    .clk_i, .rst_ni, .en_i(en), .tag_i(tag_r_q), .n_i(rsq_q),
    .pass_i(c2_q), .tag_o(tag_y), .root_o(y_root), .pass_o(c3)
  );

  // arc tangent of (sin, cos)
  tag_t                   tag_z;
  logic signed [CZ_W-1:0] z;

  vad_cordic u_cordic (
    .clk_i, .rst_ni, .en_i(en), .tag_i(tag_y),
    .x_i(signed'(CX_W'(c3))), .y_i(signed'(CX_W'(y_root))),
    .tag_o(tag_z), .z_o(z)
  );

  // supplement for negative cosine, clamp, convert to degrees
  logic signed [CX_W-1:0]    rad_s;
  logic [RAD_W-1:0]          rad_q;
  logic [DEG_PROD_W-1:0]     prod_q;
  logic [DEG_PROD_W:0]       deg_sum;
  logic [DEG_PROD_W-DEG_SH:0] deg_full;
  logic [ANGLE_W-1:0]        angle_q;
  logic                      degen_q;
  tag_t                      tag_f1_q, tag_f2_q;

  assign rad_s = tag_z.neg ? signed'(CX_W'(PI_Q30)) - CX_W'(z) : CX_W'(z);

  assign deg_sum  = (DEG_PROD_W+1)'(prod_q) + ((DEG_PROD_W+1)'(1) << (DEG_SH - 1));
  assign deg_full = deg_sum[DEG_PROD_W:DEG_SH];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (rad_s[CX_W-1]) begin
        rad_q <= '0;
      end else if (rad_s > signed'(CX_W'(PI_Q30))) begin
        rad_q <= PI_Q30;
      end else begin
        rad_q <= RAD_W'(rad_s);
      end
      prod_q <= DEG_PROD_W'(rad_q) * DEG_PROD_W'(RAD2DEG_Q24);
      if (tag_f2_q.degen) begin
        angle_q <= '0;
      end else if (deg_full > (DEG_PROD_W-DEG_SH+1)'(DEG_MAX)) begin
        angle_q <= DEG_MAX;
      end else begin
        angle_q <= ANGLE_W'(deg_full);
      end
      degen_q <= tag_f2_q.degen;
    end
  end

  // control: valid bits and sideband along the top-level stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_l_q   <= '0;
      tag_m1_q  <= '0;
      tag_m2_q  <= '0;
      tag_d_q   <= '0;
      tag_c_q   <= '0;
      tag_r_q   <= '0;
      tag_f1_q  <= '0;
      tag_f2_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      tag_l_q   <= '{vld: vld_n_q[NORM_LAT-1], degen: zero_u || zero_v, neg: 1'b0};
      tag_m1_q  <= tag_l_q;
      tag_m2_q  <= tag_m2_d;
      tag_d_q   <= tag_su;
      tag_c_q   <= tag_q_o;
      tag_r_q   <= tag_c_q;
      tag_f1_q  <= tag_z;
      tag_f2_q  <= tag_f1_q;
      out_vld_q <= tag_f2_q.vld;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.angle_deg  = angle_q;
  assign out_o.degenerate = degen_q;

  // rad_q feeds prod_q; tag_f1_q tracks it
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && degen_q |-> angle_q == '0)
    else $error("degenerate result with nonzero angle");

  a_angle_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> angle_q <= DEG_MAX)
    else $error("angle above 180 degrees");

  a_sqrt_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_su == tag_sv)
    else $error("norm root pipelines out of step");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(tag_f1_q) && $stable(rad_q))
    else $error("pipeline moved while stalled");

endmodule
